@@ rtl/pdc_pkg.sv @@
package pdc_pkg;

   // Field and datapath widths.
   localparam int CoordW   = 32;
   localparam int Axes     = 3;
   localparam int Lanes    = 2 * Axes;
   localparam int DiffW    = CoordW + 1;
   localparam int ShiftW   = 2;
   localparam int NarrowW  = 31;
   localparam int SquareW  = 2 * NarrowW;
   localparam int RadW     = 64;
   localparam int RootW    = RadW / 2;
   localparam int SqRemW   = RootW + 1;
   localparam int SqTrialW = SqRemW + 2;
   localparam int LenW     = RootW + ShiftW;
   localparam int WsumW    = CoordW + 1;
   localparam int CmagW    = LenW;
   localparam int ProdW    = LenW + WsumW;
   localparam int ProdLoW  = 34;
   localparam int ProdHiW  = ProdW - ProdLoW;
   localparam int NumW     = ProdW + CoordW;
   localparam int QuoW     = CoordW;
   localparam int DivRemW  = ProdW;
   localparam int SqrtSteps = RootW;
   localparam int DivSteps  = QuoW;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_DEGEN = 2'd1,
      STATUS_SAT   = 2'd2
   } status_type;

   // Per-edge values that ride along the square root chain.
   typedef struct packed {
      logic [Axes-1:0][DiffW-1:0] mag;
      logic [Axes-1:0]            dneg;
      logic [ShiftW-1:0]          shift;
      logic [CoordW-1:0]          w1;
      logic [CoordW-1:0]          w2;
      logic [CoordW-1:0]          rest;
   } edge_side_type;

   // Working state of one square root cell.
   typedef struct packed {
      logic [SqRemW-1:0] rem;
      logic [RootW-1:0]  root;
      logic [RadW-1:0]   rad;
   } sqrt_state_type;

   // Working state of one divider cell.
   typedef struct packed {
      logic [DivRemW-1:0] rem;
      logic [ProdW-1:0]   den;
      logic [QuoW-1:0]    low;
      logic [QuoW-1:0]    quo;
      logic               neg;
      logic               big;
   } div_state_type;

   // Control that travels beside the divider lanes.
   typedef struct packed {
      logic vld;
      logic degen;
   } div_ctrl_type;

endpackage

@@ rtl/pdc_if.sv @@
interface pdc_req_if import pdc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [CoordW-1:0] first_x;
   logic signed [CoordW-1:0] first_y;
   logic signed [CoordW-1:0] first_z;
   logic signed [CoordW-1:0] second_x;
   logic signed [CoordW-1:0] second_y;
   logic signed [CoordW-1:0] second_z;
   logic [CoordW-1:0]        first_weight;
   logic [CoordW-1:0]        second_weight;
   logic [CoordW-1:0]        rest_length;

   modport source (
      output valid, first_x, first_y, first_z, second_x, second_y, second_z,
             first_weight, second_weight, rest_length,
      input  ready
   );
   modport sink (
      input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
             first_weight, second_weight, rest_length,
      output ready
   );
endinterface

interface pdc_rsp_if import pdc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [CoordW-1:0] first_dx;
   logic signed [CoordW-1:0] first_dy;
   logic signed [CoordW-1:0] first_dz;
   logic signed [CoordW-1:0] second_dx;
   logic signed [CoordW-1:0] second_dy;
   logic signed [CoordW-1:0] second_dz;
   logic [1:0]               status;

   modport source (
      output valid, first_dx, first_dy, first_dz, second_dx, second_dy, second_dz,
             status,
      input  ready
   );
   modport sink (
      input  valid, first_dx, first_dy, first_dz, second_dx, second_dy, second_dz,
             status,
      output ready
   );
endinterface

@@ rtl/pdc_sqrt_cell.sv @@
module pdc_sqrt_cell import pdc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_vld,
   input  sqrt_state_type in_st,
   input  edge_side_type  in_side,
   output logic           out_vld,
   output sqrt_state_type out_st,
   output edge_side_type  out_side
);

   logic           vld_ff;
   sqrt_state_type st_ff;
   sqrt_state_type st_in;
   edge_side_type  side_ff;
   logic [SqTrialW-1:0] acc;
   logic [SqTrialW-1:0] trial;

   // One result bit: bring in two radicand bits and try the next root bit.
   always_comb begin
      acc      = {in_st.rem, in_st.rad[RadW-1 -: 2]};
      trial    = {1'b0, in_st.root, 2'b01};
      st_in.rad = in_st.rad << 2;
      if (acc >= trial) begin
         st_in.rem  = SqRemW'(acc - trial);
         st_in.root = {in_st.root[RootW-2:0], 1'b1};
      end else begin
         st_in.rem  = SqRemW'(acc);
         st_in.root = {in_st.root[RootW-2:0], 1'b0};
      end
   end

   // Valid bit of this cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   // Working state and the values that ride along.
   always_ff @(posedge clock) begin
      if (en) begin
         st_ff   <= st_in;
         side_ff <= in_side;
      end
   end

   assign out_vld  = vld_ff;
   assign out_st   = st_ff;
   assign out_side = side_ff;

endmodule

@@ rtl/pdc_div_cell.sv @@
module pdc_div_cell import pdc_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  div_state_type in_st,
   output div_state_type out_st
);

   div_state_type       st_ff;
   div_state_type       st_in;
   logic [DivRemW:0]    acc;
   logic [DivRemW:0]    dvs;

   // One quotient bit of a restoring division.
   always_comb begin
      st_in = in_st;
      acc   = {in_st.rem, in_st.low[QuoW-1]};
      dvs   = {1'b0, in_st.den};
      st_in.low = in_st.low << 1;
      if (acc >= dvs) begin
         st_in.rem = DivRemW'(acc - dvs);
         st_in.quo = {in_st.quo[QuoW-2:0], 1'b1};
      end else begin
         st_in.rem = acc[DivRemW-1:0];
         st_in.quo = {in_st.quo[QuoW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   assign out_st = st_ff;

endmodule

@@ rtl/pbd_distance_constraint_core.sv @@
// Channel   Dir  Transfer contents
// req_chan  in   two endpoint positions, two inverse masses, rest length
// rsp_chan  out  six position corrections and a status code
//
// One edge is taken every cycle while the output is not stalled. Each
// result passes through the 32-cell square root chain and the 32-cell
// divider chains, one bit per cell.
// Reset is synchronous and clears only the valid bits of the pipeline.
// A stalled output freezes the whole pipeline, and req_chan.ready drops.

module pbd_distance_constraint_core import pdc_pkg::*; (
   input logic     clock,
   input logic     reset,
   pdc_req_if.sink   req_chan,
   pdc_rsp_if.source rsp_chan
);

   logic adv;
   logic rsp_vld_ff;

   // Pipeline advance: the output register is free or is being drained.
   assign adv = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // ---------------------------------------------------------------
   // Capture stage: coordinate differences.
   logic [Axes-1:0][CoordW-1:0] p1;
   logic [Axes-1:0][CoordW-1:0] p2;
   logic                        a_vld_ff;
   logic [Axes-1:0][DiffW-1:0]  a_diff_ff;
   logic [Axes-1:0][DiffW-1:0]  a_diff_in;
   logic [CoordW-1:0]           a_w1_ff, a_w2_ff, a_rest_ff;

   assign p1[0] = req_chan.first_x;
   assign p1[1] = req_chan.first_y;
   assign p1[2] = req_chan.first_z;
   assign p2[0] = req_chan.second_x;
   assign p2[1] = req_chan.second_y;
   assign p2[2] = req_chan.second_z;

   always_comb begin
      for (int i = 0; i < Axes; i++) begin
         a_diff_in[i] = {p1[i][CoordW-1], p1[i]} - {p2[i][CoordW-1], p2[i]};
      end
   end

   // ---------------------------------------------------------------
   // Magnitudes and the common shift that brings them below 2^31.
   logic                          b_vld_ff;
   edge_side_type                 b_side_ff;
   edge_side_type                 b_side_in;
   logic [Axes-1:0][NarrowW-1:0]  b_nar_ff;
   logic [Axes-1:0][NarrowW-1:0]  b_nar_in;
   logic                          any_top;
   logic                          any_next;

   always_comb begin
      b_side_in.w1   = a_w1_ff;
      b_side_in.w2   = a_w2_ff;
      b_side_in.rest = a_rest_ff;
      any_top  = 1'b0;
      any_next = 1'b0;
      for (int i = 0; i < Axes; i++) begin
         b_side_in.dneg[i] = a_diff_ff[i][DiffW-1];
         b_side_in.mag[i]  = a_diff_ff[i][DiffW-1] ? -a_diff_ff[i] : a_diff_ff[i];
         any_top  = any_top  | b_side_in.mag[i][DiffW-1];
         any_next = any_next | b_side_in.mag[i][DiffW-2];
      end
      if (any_top) begin
         b_side_in.shift = ShiftW'(2);
      end else if (any_next) begin
         b_side_in.shift = ShiftW'(1);
      end else begin
         b_side_in.shift = ShiftW'(0);
      end
      for (int i = 0; i < Axes; i++) begin
         b_nar_in[i] = NarrowW'(b_side_in.mag[i] >> b_side_in.shift);
      end
   end

   // ---------------------------------------------------------------
   // Squares, then their sum.
   logic                          c_vld_ff;
   edge_side_type                 c_side_ff;
   logic [Axes-1:0][SquareW-1:0]  c_sq_ff;
   sqrt_state_type                d_st_ff;
   sqrt_state_type                d_st_in;

   always_comb begin
      d_st_in.rem  = '0;
      d_st_in.root = '0;
      d_st_in.rad  = RadW'(c_sq_ff[0]) + RadW'(c_sq_ff[1]) + RadW'(c_sq_ff[2]);
   end

   // ---------------------------------------------------------------
   // Square root chain.
   logic           sq_vld [SqrtSteps+1];
   sqrt_state_type sq_st  [SqrtSteps+1];
   edge_side_type  sq_side[SqrtSteps+1];
   logic           d_vld_ff;
   edge_side_type  d_side_ff;

   assign sq_vld[0]  = d_vld_ff;
   assign sq_st[0]   = d_st_ff;
   assign sq_side[0] = d_side_ff;

   for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
      pdc_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .in_vld   (sq_vld[k]),
         .in_st    (sq_st[k]),
         .in_side  (sq_side[k]),
         .out_vld  (sq_vld[k+1]),
         .out_st   (sq_st[k+1]),
         .out_side (sq_side[k+1])
      );
   end

   // ---------------------------------------------------------------
   // Length, total weight and constraint error.
   edge_side_type  sq_out;
   logic [LenW-1:0]  e_len_in;
   logic [WsumW-1:0] e_wsum_in;
   logic [LenW:0]    e_c;
   logic             e_vld_ff;
   logic [LenW-1:0]  e_len_ff;
   logic [WsumW-1:0] e_wsum_ff;
   logic [CmagW-1:0] e_cmag_ff;
   logic             e_cneg_ff;
   logic             e_degen_ff;
   logic [Axes-1:0][DiffW-1:0] e_mag_ff;
   logic [Axes-1:0]  e_dneg_ff;
   logic [CoordW-1:0] e_w1_ff, e_w2_ff;

   assign sq_out = sq_side[SqrtSteps];

   always_comb begin
      e_len_in  = {{ShiftW{1'b0}}, sq_st[SqrtSteps].root} << sq_out.shift;
      e_wsum_in = {1'b0, sq_out.w1} + {1'b0, sq_out.w2};
      e_c       = {1'b0, e_len_in} - {{(LenW + 1 - CoordW){1'b0}}, sq_out.rest};
   end

   // ---------------------------------------------------------------
   // First products: denominator and error times each magnitude.
   logic             f_vld_ff;
   logic [ProdW-1:0] f_den_ff;
   logic [Axes-1:0][ProdW-1:0] f_prod_ff;
   logic [Axes-1:0]  f_pos_ff;
   logic             f_degen_ff;
   logic [CoordW-1:0] f_w1_ff, f_w2_ff;

   // ---------------------------------------------------------------
   // Second products, split into a low and a high part, one pair per lane.
   // Lanes 0..2 are the first endpoint, lanes 3..5 the second.
   logic             g_vld_ff;
   logic [ProdW-1:0] g_den_ff;
   logic             g_degen_ff;
   logic [Lanes-1:0][ProdLoW+CoordW-1:0] g_lo_ff;
   logic [Lanes-1:0][ProdHiW+CoordW-1:0] g_hi_ff;
   logic [Lanes-1:0] g_neg_ff;

   // Numerators.
   logic             h_vld_ff;
   logic [ProdW-1:0] h_den_ff;
   logic             h_degen_ff;
   logic [Lanes-1:0][NumW-1:0] h_num_ff;
   logic [Lanes-1:0] h_neg_ff;

   // ---------------------------------------------------------------
   // Divider lanes.
   div_state_type dv_st [Lanes][DivSteps+1];
   div_state_type dv_init_ff[Lanes];
   div_ctrl_type  dv_ctrl_ff[DivSteps+1];

   for (genvar l = 0; l < Lanes; l++) begin : g_lane
      assign dv_st[l][0] = dv_init_ff[l];
      for (genvar k = 0; k < DivSteps; k++) begin : g_step
         pdc_div_cell u_cell (
            .clock  (clock),
            .en     (adv),
            .in_st  (dv_st[l][k]),
            .out_st (dv_st[l][k+1])
         );
      end
   end

   // ---------------------------------------------------------------
   // Saturation, sign and status.
   logic [Lanes-1:0][CoordW-1:0] rsp_val_in;
   logic [Lanes-1:0][CoordW-1:0] rsp_val_ff;
   status_type                   rsp_status_in;
   status_type                   rsp_status_ff;
   logic [Lanes-1:0]             lane_sat;

   always_comb begin
      logic [QuoW-1:0] lim;
      logic [QuoW-1:0] mag;
      for (int l = 0; l < Lanes; l++) begin
         lim = dv_st[l][DivSteps].neg ? {1'b1, {(QuoW-1){1'b0}}} : {1'b0, {(QuoW-1){1'b1}}};
         lane_sat[l] = dv_st[l][DivSteps].big || (dv_st[l][DivSteps].quo > lim);
         mag = lane_sat[l] ? lim : dv_st[l][DivSteps].quo;
         if (dv_ctrl_ff[DivSteps].degen) begin
            rsp_val_in[l] = '0;
         end else begin
            rsp_val_in[l] = dv_st[l][DivSteps].neg ? -mag : mag;
         end
      end
      if (dv_ctrl_ff[DivSteps].degen) begin
         rsp_status_in = STATUS_DEGEN;
      end else if (|lane_sat) begin
         rsp_status_in = STATUS_SAT;
      end else begin
         rsp_status_in = STATUS_OK;
      end
   end

   // ---------------------------------------------------------------
   // Valid bits of the stages outside the cell chains, and the control
   // that travels beside the divider lanes.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         d_vld_ff   <= 1'b0;
         e_vld_ff   <= 1'b0;
         f_vld_ff   <= 1'b0;
         g_vld_ff   <= 1'b0;
         h_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int k = 0; k <= DivSteps; k++) begin
            dv_ctrl_ff[k].vld <= 1'b0;
         end
      end else if (adv) begin
         a_vld_ff   <= req_chan.valid;
         b_vld_ff   <= a_vld_ff;
         c_vld_ff   <= b_vld_ff;
         d_vld_ff   <= c_vld_ff;
         e_vld_ff   <= sq_vld[SqrtSteps];
         f_vld_ff   <= e_vld_ff;
         g_vld_ff   <= f_vld_ff;
         h_vld_ff   <= g_vld_ff;
         dv_ctrl_ff[0].vld   <= h_vld_ff;
         dv_ctrl_ff[0].degen <= h_degen_ff;
         for (int k = 1; k <= DivSteps; k++) begin
            dv_ctrl_ff[k].vld   <= dv_ctrl_ff[k-1].vld;
            dv_ctrl_ff[k].degen <= dv_ctrl_ff[k-1].degen;
         end
         rsp_vld_ff <= dv_ctrl_ff[DivSteps].vld;
      end
   end

   // Datapath registers of those stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         a_diff_ff <= a_diff_in;
         a_w1_ff   <= req_chan.first_weight;
         a_w2_ff   <= req_chan.second_weight;
         a_rest_ff <= req_chan.rest_length;

         b_side_ff <= b_side_in;
         b_nar_ff  <= b_nar_in;

         c_side_ff <= b_side_ff;
         for (int i = 0; i < Axes; i++) begin
            c_sq_ff[i] <= b_nar_ff[i] * b_nar_ff[i];
         end

         d_side_ff <= c_side_ff;
         d_st_ff   <= d_st_in;

         e_len_ff   <= e_len_in;
         e_wsum_ff  <= e_wsum_in;
         e_cneg_ff  <= e_c[LenW];
         e_cmag_ff  <= e_c[LenW] ? CmagW'(-e_c) : CmagW'(e_c);
         e_degen_ff <= (e_len_in == '0) || (e_wsum_in == '0);
         e_mag_ff   <= sq_out.mag;
         e_dneg_ff  <= sq_out.dneg;
         e_w1_ff    <= sq_out.w1;
         e_w2_ff    <= sq_out.w2;

         f_den_ff   <= ProdW'(e_len_ff) * ProdW'(e_wsum_ff);
         for (int i = 0; i < Axes; i++) begin
            f_prod_ff[i] <= ProdW'(e_cmag_ff) * ProdW'(e_mag_ff[i]);
            f_pos_ff[i]  <= (e_cneg_ff == e_dneg_ff[i]);
         end
         f_degen_ff <= e_degen_ff;
         f_w1_ff    <= e_w1_ff;
         f_w2_ff    <= e_w2_ff;

         g_den_ff   <= f_den_ff;
         g_degen_ff <= f_degen_ff;
         for (int i = 0; i < Axes; i++) begin
            g_lo_ff[i] <= (ProdLoW+CoordW)'(f_prod_ff[i][ProdLoW-1:0]) *
                          (ProdLoW+CoordW)'(f_w1_ff);
            g_hi_ff[i] <= (ProdHiW+CoordW)'(f_prod_ff[i][ProdW-1:ProdLoW]) *
                          (ProdHiW+CoordW)'(f_w1_ff);
            g_neg_ff[i] <= f_pos_ff[i];
            g_lo_ff[i+Axes] <= (ProdLoW+CoordW)'(f_prod_ff[i][ProdLoW-1:0]) *
                               (ProdLoW+CoordW)'(f_w2_ff);
            g_hi_ff[i+Axes] <= (ProdHiW+CoordW)'(f_prod_ff[i][ProdW-1:ProdLoW]) *
                               (ProdHiW+CoordW)'(f_w2_ff);
            g_neg_ff[i+Axes] <= !f_pos_ff[i];
         end

         h_den_ff   <= g_den_ff;
         h_degen_ff <= g_degen_ff;
         h_neg_ff   <= g_neg_ff;
         for (int l = 0; l < Lanes; l++) begin
            h_num_ff[l] <= NumW'(g_lo_ff[l]) + (NumW'(g_hi_ff[l]) << ProdLoW);
         end

         // Divider entry: overflow check and the initial partial remainder.
         for (int l = 0; l < Lanes; l++) begin
            dv_init_ff[l].rem <= h_num_ff[l][NumW-1:QuoW];
            dv_init_ff[l].low <= h_num_ff[l][QuoW-1:0];
            dv_init_ff[l].den <= h_den_ff;
            dv_init_ff[l].quo <= '0;
            dv_init_ff[l].neg <= h_neg_ff[l];
            dv_init_ff[l].big <= h_num_ff[l] >= {h_den_ff, {QuoW{1'b0}}};
         end

         rsp_val_ff    <= rsp_val_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // Output channel.
   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.first_dx  = rsp_val_ff[0];
   assign rsp_chan.first_dy  = rsp_val_ff[1];
   assign rsp_chan.first_dz  = rsp_val_ff[2];
   assign rsp_chan.second_dx = rsp_val_ff[3];
   assign rsp_chan.second_dy = rsp_val_ff[4];
   assign rsp_chan.second_dz = rsp_val_ff[5];
   assign rsp_chan.status    = rsp_status_ff;

endmodule

@@ rtl/pdc_checker.sv @@
module pdc_checker import pdc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_status,
   input logic [CoordW-1:0] first_dx,
   input logic [CoordW-1:0] first_dy,
   input logic [CoordW-1:0] first_dz,
   input logic [CoordW-1:0] second_dx,
   input logic [CoordW-1:0] second_dy,
   input logic [CoordW-1:0] second_dz
);

   // A result that is offered stays offered until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // The input side stalls exactly when a waiting result is not taken.
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

   // A degenerate edge gives no correction at all.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_DEGEN |->
         first_dx == '0 && first_dy == '0 && first_dz == '0 &&
         second_dx == '0 && second_dy == '0 && second_dz == '0)
      else $error("degenerate result with nonzero correction");

   // With status OK and both x corrections nonzero, the endpoints move in opposite x directions.
   a_opposite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK && first_dx != '0 && second_dx != '0 |->
         first_dx[CoordW-1] != second_dx[CoordW-1])
      else $error("endpoint corrections point the same way");

endmodule

bind pbd_distance_constraint_core pdc_checker u_pdc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .first_dx   (rsp_chan.first_dx),
   .first_dy   (rsp_chan.first_dy),
   .first_dz   (rsp_chan.first_dz),
   .second_dx  (rsp_chan.second_dx),
   .second_dy  (rsp_chan.second_dy),
   .second_dz  (rsp_chan.second_dz)
);

@@ bench/pdc_checker.sv @@
module pdc_scoreboard import pdc_pkg::*; (
   input  logic clock,
   input  logic reset,
   pdc_req_if   req_chan,
   pdc_rsp_if   rsp_chan,
   output int   fail_count,
   output int   pending,
   output int   checked
);

   // One predicted set of corrections: x, y, z of the first endpoint, then of the second.
   typedef struct {
      logic [5:0][CoordW-1:0] corr;
      status_type             status;
   } correction_type;

   correction_type expected_corrections[$];

   // Integer square root, floor, of a 64-bit radicand.
   function automatic logic [63:0] floor_sqrt(input logic [63:0] radicand);
      logic [64:0] x;
      logic [64:0] root;
      logic [64:0] bitpos;
      x = {1'b0, radicand};
      root = '0;
      bitpos = 65'd1 << 62;
      while (bitpos > x) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (x >= root + bitpos) begin
            x = x - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return root[63:0];
   endfunction

   // One correction component: w * |C| * |d| / (len * W), truncated, signed and clamped.
   function automatic logic [CoordW-1:0] scaled_correction(
      input logic [127:0] weight, input logic [127:0] cmag, input logic [127:0] dmag,
      input logic [127:0] denom, input logic negative, inout logic saturated);
      logic [127:0] quotient;
      logic [127:0] limit;
      quotient = (weight * cmag * dmag) / denom;
      limit = negative ? (128'd1 << (CoordW - 1)) : (128'd1 << (CoordW - 1)) - 1;
      if (quotient > limit) begin
         quotient = limit;
         saturated = 1'b1;
      end
      return negative ? (~quotient[CoordW-1:0] + 1'b1) : quotient[CoordW-1:0];
   endfunction

   // Projects one distance constraint the way the block is meant to.
   function automatic correction_type project_edge(
      input logic [2:0][CoordW-1:0] first_pos, input logic [2:0][CoordW-1:0] second_pos,
      input logic [CoordW-1:0] w1, input logic [CoordW-1:0] w2,
      input logic [CoordW-1:0] rest);
      correction_type res;
      logic signed [CoordW+1:0] diff[3];
      logic [CoordW:0] dmag[3];
      logic [63:0] sumsq;
      logic [63:0] narrowed;
      logic [127:0] len;
      logic [127:0] wsum;
      logic [127:0] cmag;
      logic [127:0] denom;
      logic cneg;
      logic first_neg;
      logic saturated;
      logic needs_shift;
      int shift;
      for (int i = 0; i < 3; i++) begin
         diff[i] = $signed(first_pos[i]) - $signed(second_pos[i]);
         dmag[i] = (CoordW+1)'(diff[i] < 0 ? -diff[i] : diff[i]);
      end
      shift = 0;
      do begin
         needs_shift = 1'b0;
         for (int i = 0; i < 3; i++)
            if ((dmag[i] >> shift) >= (33'd1 << 31)) needs_shift = 1'b1;
         if (needs_shift) shift++;
      end while (needs_shift);
      sumsq = '0;
      for (int i = 0; i < 3; i++) begin
         narrowed = 64'(dmag[i] >> shift);
         sumsq = sumsq + narrowed * narrowed;
      end
      len = 128'(floor_sqrt(sumsq)) << shift;
      wsum = 128'(w1) + 128'(w2);
      res.corr = '0;
      res.status = STATUS_OK;
      if (len == 0 || wsum == 0) begin
         res.status = STATUS_DEGEN;
         return res;
      end
      // Constraint error C = len - rest, kept as sign and magnitude.
      cneg = len < 128'(rest);
      cmag = cneg ? 128'(rest) - len : len - 128'(rest);
      denom = len * wsum;
      saturated = 1'b0;
      for (int i = 0; i < 3; i++) begin
         first_neg = (cneg == (diff[i] < 0));
         if (cmag != 0 && dmag[i] != 0) begin
            res.corr[i] = scaled_correction(128'(w1), cmag, 128'(dmag[i]), denom,
                                            first_neg, saturated);
            res.corr[i+3] = scaled_correction(128'(w2), cmag, 128'(dmag[i]), denom,
                                              !first_neg, saturated);
         end
      end
      if (saturated) res.status = STATUS_SAT;
      return res;
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
      checked = 0;
   end

   // Predict on each input transfer; compare each result transfer with the oldest prediction.
   always @(posedge clock) begin
      correction_type exp_corr;
      logic [5:0][CoordW-1:0] got;
      string names[6];
      int errs;
      names = '{"first_dx", "first_dy", "first_dz", "second_dx", "second_dy", "second_dz"};
      errs = 0;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            expected_corrections = {expected_corrections, project_edge(
               {req_chan.first_z, req_chan.first_y, req_chan.first_x},
               {req_chan.second_z, req_chan.second_y, req_chan.second_x},
               req_chan.first_weight, req_chan.second_weight, req_chan.rest_length)};
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.second_dz, rsp_chan.second_dy, rsp_chan.second_dx,
                   rsp_chan.first_dz, rsp_chan.first_dy, rsp_chan.first_dx};
            if (expected_corrections.size() == 0) begin
               $error("result transfer with no prediction outstanding");
               errs++;
            end else begin
               exp_corr = expected_corrections.pop_front();
               for (int k = 0; k < 6; k++)
                  if (got[k] !== exp_corr.corr[k]) begin
                     $error("%s expected %0d actual %0d", names[k],
                            $signed(exp_corr.corr[k]), $signed(got[k]));
                     errs++;
                  end
               if (rsp_chan.status !== exp_corr.status) begin
                  $error("status expected %0d actual %0d", exp_corr.status, rsp_chan.status);
                  errs++;
               end
            end
            checked <= checked + 1;
         end
      end
      fail_count <= fail_count + errs;
      pending <= expected_corrections.size();
   end

endmodule

@@ bench/tb.sv @@
module tb;

   localparam logic [31:0] One     = 32'h0001_0000;
   localparam logic [31:0] MaxPos  = 32'h7fff_ffff;
   localparam logic [31:0] MinNeg  = 32'h8000_0000;
   localparam logic [31:0] AllOnes = 32'hffff_ffff;
   localparam int RandomEdges = 430;

   logic clock;
   logic reset;
   logic no_idle;
   int   fail_count;
   int   pending;
   int   checked;
   int   sent;

   pdc_req_if req_chan ();
   pdc_rsp_if rsp_chan ();

   pbd_distance_constraint_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pdc_scoreboard constraint_checker (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Offers one edge after a random gap (none while no_idle is set) and holds it until the transfer.
   task automatic send_edge(input logic [31:0] fx, input logic [31:0] fy,
                            input logic [31:0] fz, input logic [31:0] sx,
                            input logic [31:0] sy, input logic [31:0] sz,
                            input logic [31:0] w1, input logic [31:0] w2,
                            input logic [31:0] rest);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.first_x       <= fx;
      req_chan.first_y       <= fy;
      req_chan.first_z       <= fz;
      req_chan.second_x      <= sx;
      req_chan.second_y      <= sy;
      req_chan.second_z      <= sz;
      req_chan.first_weight  <= w1;
      req_chan.second_weight <= w2;
      req_chan.rest_length   <= rest;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
   endtask

   function automatic logic [31:0] corner_value();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return MaxPos;
         2: return MinNeg;
         3: return AllOnes;
         4: return 32'd1;
         default: return $urandom;
      endcase
   endfunction

   // Random edge: mostly cloth-like geometry, some full-range noise, degenerate edges and corners.
   task automatic send_random_edge();
      logic [31:0] p[6];
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] rest;
      int mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         p[i] = 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
         p[i+3] = p[i] + 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      end
      w1 = $urandom_range(0, 32'h0002_0000);
      w2 = $urandom_range(0, 32'h0002_0000);
      rest = $urandom_range(0, 32'h0006_0000);
      if (mode == 6 || mode == 7) begin
         for (int i = 0; i < 6; i++) p[i] = $urandom;
         w1 = $urandom;
         w2 = $urandom;
         rest = $urandom;
      end else if (mode == 8) begin
         if ($urandom_range(0, 1)) for (int i = 0; i < 3; i++) p[i+3] = p[i];
         else begin
            w1 = '0;
            w2 = '0;
         end
      end else if (mode == 9) begin
         for (int i = 0; i < 6; i++) p[i] = corner_value();
         w1 = corner_value();
         w2 = corner_value();
         rest = corner_value();
      end
      send_edge(p[0], p[1], p[2], p[3], p[4], p[5], w1, w2, rest);
   endtask

   // Result side: random stalls before each transfer, none during bursts.
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin
      #(8 * 200000);
      $display("FAIL");
      $finish;
   end

   initial begin
      int settle;
      sent = 0;
      no_idle = 1'b0;
      reset <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.first_x       <= '0;
      req_chan.first_y       <= '0;
      req_chan.first_z       <= '0;
      req_chan.second_x      <= '0;
      req_chan.second_y      <= '0;
      req_chan.second_z      <= '0;
      req_chan.first_weight  <= '0;
      req_chan.second_weight <= '0;
      req_chan.rest_length   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed edges: degenerate cases, zero error, extremes and saturation.
      send_edge(One, One, One, One, One, One, One, One, One);
      send_edge(3 * One, 4 * One, 0, 0, 0, 0, 0, 0, One);
      send_edge(3 * One, 4 * One, 0, 0, 0, 0, One, 2 * One, 5 * One);
      send_edge(3 * One, 4 * One, 0, 0, 0, 0, One, One, 2 * One);
      send_edge(3 * One, 4 * One, 0, 0, 0, 0, One, One, 9 * One);
      send_edge(-3 * One, 0, 4 * One, 0, 0, 0, 0, One, One);
      send_edge(MaxPos, MaxPos, MaxPos, MinNeg, MinNeg, MinNeg, One, One, 0);
      send_edge(MinNeg, MinNeg, MinNeg, MaxPos, MaxPos, MaxPos, AllOnes, AllOnes, AllOnes);
      send_edge(MaxPos, 0, 0, MinNeg, 0, 0, AllOnes, 1, 0);
      send_edge(1, 0, 0, 0, 0, 0, One, One, AllOnes);
      send_edge(0, 1, 1, 0, 0, 0, AllOnes, 0, AllOnes);
      send_edge(0, 0, 1, 0, 0, 0, 1, AllOnes, MaxPos);
      send_edge(AllOnes, AllOnes, AllOnes, 0, 0, 0, One, One, 0);
      send_edge(0, 0, 0, 0, 0, 0, AllOnes, AllOnes, 0);
      send_edge(MaxPos, MinNeg, AllOnes, 0, 1, MaxPos, 32'h5555_5555, 32'haaaa_aaaa,
                32'h1234_5678);
      send_edge(AllOnes, 0, 0, 0, 0, 0, 1, 1, 1);

      // Hold the sender until the pipeline has drained completely.
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      for (int n = 0; n < RandomEdges; n++) begin
         no_idle = (n >= 150 && n < 230);
         send_random_edge();
      end
      no_idle = 1'b0;
      req_chan.valid <= 1'b0;

      settle = 0;
      while (pending != 0 && settle < 20000) begin
         @(posedge clock);
         settle++;
      end
      repeat (100) @(posedge clock);
      $display("Sent %0d edges, directed corners and random geometry; checked %0d results.",
               sent, checked);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/pdc_pkg.sv
rtl/pdc_if.sv
rtl/pdc_sqrt_cell.sv
rtl/pdc_div_cell.sv
rtl/pbd_distance_constraint_core.sv
rtl/pdc_checker.sv
bench/pdc_checker.sv
bench/tb.sv
